FILE: rtl/cfd_pkg.sv
`default_nettype none
package cfd_pkg;

    localparam int NUM_WEIGHTS = 26;
    localparam int NUM_LAYERS  = 53;
    localparam int ODD_SLOTS   = 14;

    localparam int SLOT_W  = 5;
    localparam int WGT_W   = 16;
    localparam int LAYER_W = 6;
    localparam int ENE_W   = 16;
    localparam int ETOT_W  = 22;
    localparam int WSUM_W  = 40;
    localparam int PROD_W  = WGT_W + ENE_W + 1;
    localparam int SCORE_W = 20;
    localparam int NUM_W   = WSUM_W + 1;
    localparam int DEN_W   = ETOT_W + 1;
    localparam int QCNT_W  = 5;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    localparam logic [0:0] FUNC_LOAD = 1'b0;
    localparam logic [0:0] FUNC_HIT  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_slot_map;

    // Odd layers 1..27 use slots 0..13, layers 29..40 use slot layer-15; all other layers miss.
    function automatic t_slot_map layer_slot(input logic [LAYER_W-1:0] layer);
        t_slot_map        m;
        logic [LAYER_W:0] s;
        m = '0;
        s = '0;
        if (layer < LAYER_W'(NUM_LAYERS)) begin
            if (layer >= LAYER_W'(1) && layer <= LAYER_W'(2 * ODD_SLOTS - 1) && layer[0]) begin
                s     = {2'b00, layer[LAYER_W-1:1]};
                m.hit = 1'b1;
            end else if (layer >= LAYER_W'(2 * ODD_SLOTS + 1)) begin
                s     = {1'b0, layer} - (LAYER_W + 1)'(15);
                m.hit = 1'b1;
            end
        end
        if (s >= (LAYER_W + 1)'(NUM_WEIGHTS)) begin
            m.hit = 1'b0;
        end
        m.slot = s[SLOT_W-1:0];
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/cfd_wtab.sv
`default_nettype none
module cfd_wtab
    import cfd_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_wr_en,
    input  wire        [SLOT_W-1:0] i_wr_slot,
    input  wire        [WGT_W-1:0]  i_wr_data,
    input  wire                     i_rd_en,
    input  wire t_slot_map          i_rd_map,
    output logic       [WGT_W-1:0]  o_rd_data
);

    logic [WGT_W-1:0] r_mem [NUM_WEIGHTS];
    logic [WGT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
                r_mem[i] <= '0;
            end
        end else if (i_wr_en && i_wr_slot < SLOT_W'(NUM_WEIGHTS)) begin
            r_mem[i_wr_slot] <= i_wr_data;
        end
    end

    // Unmapped layers read as a zero weight, so they add nothing to the sum.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= i_rd_map.hit ? r_mem[i_rd_map.slot] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: rtl/cfd_div.sv
`default_nettype none
module cfd_div
    import cfd_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire        [NUM_W-1:0]   i_num,
    input  wire        [DEN_W-1:0]   i_den,
    output t_div_stat                o_stat,
    output logic       [SCORE_W-1:0] o_quot
);

    // Restoring divider, one quotient bit per cycle. The caller guarantees
    // that the top bits of the numerator are already below the divisor.
    logic [DEN_W-1:0]   r_rem,  n_rem;
    logic [DEN_W-1:0]   r_den;
    logic [SCORE_W-1:0] r_nlow, n_nlow;
    logic [SCORE_W-1:0] r_quot, n_quot;
    logic [QCNT_W-1:0]  r_cnt,  n_cnt;
    logic               r_busy, n_busy;
    logic [DEN_W:0]     rem_sh;
    logic               ge;

    always_comb begin
        rem_sh = {r_rem, r_nlow[SCORE_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        n_rem  = r_rem;
        n_nlow = r_nlow;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_rem  = DEN_W'(i_num[NUM_W-1:SCORE_W]);
            n_nlow = i_num[SCORE_W-1:0];
            n_quot = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = ge ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
            n_nlow = {r_nlow[SCORE_W-2:0], 1'b0};
            n_quot = {r_quot[SCORE_W-2:0], ge};
            n_cnt  = r_cnt + QCNT_W'(1);
            if (r_cnt == QCNT_W'(SCORE_W - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_nlow <= n_nlow;
        r_quot <= n_quot;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && r_cnt == QCNT_W'(SCORE_W - 1);
    assign o_quot      = r_quot;

endmodule
`default_nettype wire

FILE: rtl/cluster_fisher_discriminant_top.sv
// Weight loads leave the block in idle, so it is ready again on the next cycle.
// A hit that is not the last of its cluster passes through table read,
// multiply and saturating accumulate before the next item is taken.
// A last hit goes on from those steps through a setup step and the bit-serial
// divider, then the score is formed into the output register once it is free.
// Reset (synchronous, active low) clears the weight table and both sums.
`default_nettype none
module cluster_fisher_discriminant_top
    import cfd_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // weight_slot[4:0], weight_value[20:5], layer_number[26:21],
    // hit_energy[42:27], zero fill
    input  wire [IN_DATA_W-1:0]    s_axis_tdata,
    // func[0]
    input  wire [0:0]              s_axis_tuser,
    input  wire                    s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // fisher_score[19:0], zero fill
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // empty_cluster[0]
    output logic [0:0]             m_axis_tuser
);

    t_state r_state, n_state;

    logic [SLOT_W-1:0]  in_slot;
    logic [WGT_W-1:0]   in_wval;
    logic [LAYER_W-1:0] in_layer;
    logic [ENE_W-1:0]   in_energy;
    logic               accept;
    t_slot_map          in_map;

    logic [WGT_W-1:0]          weight;
    logic [ENE_W-1:0]          r_energy;
    logic                      r_last;
    logic signed [PROD_W-1:0]  r_prod;
    logic [ETOT_W-1:0]         r_etot, n_etot;
    logic signed [WSUM_W-1:0]  r_wsum, n_wsum;
    logic [ETOT_W:0]           etot_sum;
    logic signed [NUM_W-1:0]   wsum_sum;

    logic                      r_neg, r_empty, r_ovf;
    logic [WSUM_W-1:0]         mag;
    logic [NUM_W-1:0]          num;
    logic [DEN_W-1:0]          den;
    logic                      ovf;
    logic                      div_start;
    t_div_stat                 div_stat;
    logic [SCORE_W-1:0]        quot;
    logic [SCORE_W-1:0]        score;

    logic                      r_m_valid;
    logic [SCORE_W-1:0]        r_m_score;
    logic                      r_m_empty;
    logic                      out_free;
    logic                      out_load;
    logic                      clear_acc;

    assign in_slot   = s_axis_tdata[4:0];
    assign in_wval   = s_axis_tdata[20:5];
    assign in_layer  = s_axis_tdata[26:21];
    assign in_energy = s_axis_tdata[42:27];
    assign in_map    = layer_slot(in_layer);

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;

    cfd_wtab u_wtab (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept && s_axis_tuser == FUNC_LOAD),
        .i_wr_slot (in_slot),
        .i_wr_data (in_wval),
        .i_rd_en   (accept && s_axis_tuser == FUNC_HIT),
        .i_rd_map  (in_map),
        .o_rd_data (weight)
    );

    cfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_stat  (div_stat),
        .o_quot  (quot)
    );

    // Sequencer
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        clear_acc     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && s_axis_tuser == FUNC_HIT) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = r_last ? S_PREP : S_IDLE;
            end
            S_PREP: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    clear_acc = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Saturating accumulators
    always_comb begin
        etot_sum = {1'b0, r_etot} + (ETOT_W + 1)'(r_energy);
        n_etot   = etot_sum[ETOT_W] ? '1 : etot_sum[ETOT_W-1:0];
        wsum_sum = NUM_W'(r_wsum) + NUM_W'(r_prod);
        if (wsum_sum[NUM_W-1] != wsum_sum[NUM_W-2]) begin
            n_wsum = wsum_sum[NUM_W-1] ? {1'b1, {(WSUM_W-1){1'b0}}}
                                       : {1'b0, {(WSUM_W-1){1'b1}}};
        end else begin
            n_wsum = wsum_sum[WSUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etot <= '0;
            r_wsum <= '0;
        end else if (clear_acc) begin
            r_etot <= '0;
            r_wsum <= '0;
        end else if (r_state == S_ACC) begin
            r_etot <= n_etot;
            r_wsum <= n_wsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_energy <= in_energy;
            r_last   <= s_axis_tlast;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'($signed(weight)) * PROD_W'($signed({1'b0, r_energy}));
        end
    end

    // Rounded quotient: (2|sum| + E) / 2E; results beyond the signed 20-bit score range saturate.
    always_comb begin
        mag = r_wsum[WSUM_W-1] ? WSUM_W'(-r_wsum) : WSUM_W'(r_wsum);
        num = {mag, 1'b0} + NUM_W'(r_etot);
        den = {r_etot, 1'b0};
        ovf = {2'b00, num} >= {den, {SCORE_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_neg   <= r_wsum[WSUM_W-1];
            r_empty <= r_etot == '0;
            r_ovf   <= ovf;
        end
    end

    always_comb begin
        if (r_empty) begin
            score = '0;
        end else if (r_neg) begin
            if (r_ovf || (quot[SCORE_W-1] && quot[SCORE_W-2:0] != '0)) begin
                score = {1'b1, {(SCORE_W-1){1'b0}}};
            end else begin
                score = SCORE_W'(-quot);
            end
        end else begin
            if (r_ovf || quot[SCORE_W-1]) begin
                score = {1'b0, {(SCORE_W-1){1'b1}}};
            end else begin
                score = quot;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_score <= score;
            r_m_empty <= r_empty;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - SCORE_W){1'b0}}, r_m_score};
    assign m_axis_tuser  = r_m_empty;

    a_ready_not_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !div_stat.busy)
        else $error("input ready while divider busy");

    a_hit_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_HIT) |=> !s_axis_tready)
        else $error("hit transaction did not hold off input");

    a_empty_zero_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("empty cluster with nonzero score");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_m_valid || m_axis_tready))
        else $error("result overwrote pending transaction");

endmodule
`default_nettype wire

FILE: test/tb_cluster_fisher_discriminant_top.sv
`default_nettype none
module tb_cluster_fisher_discriminant_top;
    import cfd_pkg::*;

    localparam int     CYCLE_LIMIT   = 600000;
    localparam int     RAND_ITEMS    = 550;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     LONG_HITS     = 260;
    localparam longint WSUM_LIM      = 64'sd549755813887;
    localparam longint ETOT_LIM      = 64'sd4194303;
    localparam longint SCORE_POS_LIM = 64'sd524287;
    localparam longint SCORE_NEG_LIM = 64'sd524288;

    typedef struct {
        bit [0:0]  func;
        bit [4:0]  slot;
        bit [15:0] wval;
        bit [5:0]  layer;
        bit [15:0] energy;
        bit        last;
        bit        known;
        bit [19:0] k_score;
        bit        k_empty;
    } t_stim_row;

    typedef struct {
        bit [19:0] score;
        bit        empty;
    } t_score_exp;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // weight_slot[4:0], weight_value[20:5], layer_number[26:21],
    // hit_energy[42:27], zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // func[0]
    logic [0:0]            s_axis_tuser  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // fisher_score[19:0], zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // empty_cluster[0]
    logic [0:0]            m_axis_tuser;

    cluster_fisher_discriminant_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Mirror of the block state
    logic signed [15:0] wtab [NUM_WEIGHTS];
    longint             wsum;
    longint             etot;

    t_score_exp  score_q[$];
    t_score_exp  got_exp;
    t_stim_row   dir_rows[$];
    int          errors      = 0;
    int          n_items     = 0;
    int          src_idle    = 38;
    int          snk_idle    = 57;
    bit          hold_req    = 1'b0;
    bit          hold_done   = 1'b0;
    int          hold_cnt    = 0;
    longint      cycle_cnt   = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_stim_row row(input bit [0:0] func, input bit [4:0] slot,
                                      input bit [15:0] wval, input bit [5:0] layer,
                                      input bit [15:0] energy, input bit last,
                                      input bit known, input bit [19:0] k_score,
                                      input bit k_empty);
        t_stim_row r;
        r.func    = func;
        r.slot    = slot;
        r.wval    = wval;
        r.layer   = layer;
        r.energy  = energy;
        r.last    = last;
        r.known   = known;
        r.k_score = k_score;
        r.k_empty = k_empty;
        return r;
    endfunction

    function automatic int slot_of_layer(input bit [5:0] layer);
        int s;
        s = -1;
        if (layer < NUM_LAYERS) begin
            if (layer[0] && layer <= 2 * ODD_SLOTS - 1)
                s = int'(layer >> 1);
            else if (layer >= 2 * ODD_SLOTS + 1)
                s = int'(layer) - 15;
        end
        if (s >= NUM_WEIGHTS)
            s = -1;
        return s;
    endfunction

    // Apply one item to the mirror (weight load or accumulate); flag a score on a last hit.
    task automatic score_cluster(input t_stim_row r, output bit has, output t_score_exp e);
        int              s;
        bit              neg;
        longint unsigned mag;
        longint unsigned q;
        longint          sc;
        has = 1'b0;
        e   = '{score: '0, empty: 1'b0};
        if (r.func == FUNC_LOAD) begin
            if (r.slot < NUM_WEIGHTS)
                wtab[r.slot] = r.wval;
            return;
        end
        etot = etot + longint'(r.energy);
        if (etot > ETOT_LIM)
            etot = ETOT_LIM;
        s = slot_of_layer(r.layer);
        if (s >= 0) begin
            wsum = wsum + longint'(wtab[s]) * longint'(r.energy);
            if (wsum > WSUM_LIM)
                wsum = WSUM_LIM;
            if (wsum < -WSUM_LIM - 1)
                wsum = -WSUM_LIM - 1;
        end
        if (!r.last)
            return;
        has = 1'b1;
        if (etot == 0) begin
            e.empty = 1'b1;
        end else begin
            neg = (wsum < 0);
            mag = neg ? longint'(-wsum) : longint'(wsum);
            q   = (mag * 2 + longint'(etot)) / (longint'(etot) * 2);
            if (neg)
                sc = (q > SCORE_NEG_LIM) ? -SCORE_NEG_LIM : -longint'(q);
            else
                sc = (q > SCORE_POS_LIM) ? SCORE_POS_LIM : longint'(q);
            e.score = sc[19:0];
        end
        wsum = 0;
        etot = 0;
    endtask

    task automatic send_item(input t_stim_row r);
        bit         has;
        t_score_exp e;
        if ($urandom_range(0, 99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, r.energy, r.layer, r.wval, r.slot};
        s_axis_tuser  <= r.func;
        s_axis_tlast  <= r.last;
        do @(posedge i_clk); while (!s_axis_tready);
        score_cluster(r, has, e);
        if (has) begin
            if (r.known)
                e = '{score: r.k_score, empty: r.k_empty};
            score_q.push_back(e);
        end
        n_items++;
    endtask

    task automatic send_load();
        bit [15:0] v;
        bit [4:0]  slot;
        slot = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, NUM_WEIGHTS - 1))
                                            : 5'($urandom_range(NUM_WEIGHTS, 31));
        case ($urandom_range(0, 9))
            0:       v = 16'h7fff;
            1:       v = 16'h8000;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        send_item(row(FUNC_LOAD, slot, v, 6'($urandom_range(0, 63)),
                      16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 0, 0, 0));
    endtask

    task automatic send_hit(input bit last, input bit zero_e);
        int        s;
        bit [5:0]  layer;
        bit [15:0] en;
        if ($urandom_range(0, 99) < 70) begin
            s     = $urandom_range(0, NUM_WEIGHTS - 1);
            layer = (s < ODD_SLOTS) ? 6'(2 * s + 1) : 6'(s + 15);
        end else begin
            layer = 6'($urandom_range(0, 63));
        end
        case ($urandom_range(0, 9))
            0:       en = 16'd0;
            1:       en = 16'hffff;
            2, 3:    en = 16'($urandom_range(0, 255));
            default: en = 16'($urandom_range(0, 65535));
        endcase
        if (zero_e)
            en = 16'd0;
        send_item(row(FUNC_HIT, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)),
                      layer, en, last, 0, 0, 0));
    endtask

    // Result side: check each transaction, stall at random, one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (score_q.size() == 0) begin
                $error("result with nothing expected: fisher_score %0h empty_cluster %0b",
                       m_axis_tdata[19:0], m_axis_tuser[0]);
                errors++;
            end else begin
                got_exp = score_q.pop_front();
                if (m_axis_tdata[19:0] !== got_exp.score) begin
                    $error("fisher_score: expected %0h, got %0h", got_exp.score,
                           m_axis_tdata[19:0]);
                    errors++;
                end
                if (m_axis_tuser[0] !== got_exp.empty) begin
                    $error("empty_cluster: expected %0b, got %0b", got_exp.empty,
                           m_axis_tuser[0]);
                    errors++;
                end
            end
        end
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    initial begin
        int  i;
        int  len;
        bit  zero_e;
        bit  long_done;
        long_done = 1'b0;
        for (i = 0; i < NUM_WEIGHTS; i++)
            wtab[i] = '0;
        wsum = 0;
        etot = 0;

        // empty cluster and all-zero weights straight after reset
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000,  1, 16'd0,     1, 1, 0, 1));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000,  3, 16'd100,   0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000, 52, 16'hffff,  1, 1, 0, 0));
        // weight extremes, out-of-range slots, last flag on loads
        dir_rows.push_back(row(FUNC_LOAD, 0, 16'h7fff,  0, 16'd0,     0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_LOAD, 25, 16'h8000, 0, 16'd0,     0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_LOAD, 26, 16'h7fff, 0, 16'd0,     0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_LOAD, 31, 16'hffff, 63, 16'hffff, 1, 0, 0, 0));
        dir_rows.push_back(row(FUNC_LOAD, 13, 16'h1000, 0, 16'd0,     1, 0, 0, 0));
        // weight 1.0 on a single hit scores exactly 1.0
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000, 27, 16'hffff,  1, 1, 20'h01000, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000,  1, 16'hffff,  0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000, 40, 16'hffff,  0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000,  0, 16'd1,     0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000, 28, 16'd12345, 1, 0, 0, 0));
        // unmapped layers only: zero numerator
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000, 53, 16'd1000,  0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000, 63, 16'd2000,  0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000, 41, 16'd3000,  0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000,  2, 16'd0,     1, 1, 0, 0));
        // load in the middle of a cluster
        dir_rows.push_back(row(FUNC_LOAD, 2, 16'hf000,  0, 16'd0,     0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000,  5, 16'd300,   0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_LOAD, 2, 16'h2000,  0, 16'd0,     0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000,  5, 16'd100,   1, 0, 0, 0));
        // hits present but zero energy
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000, 29, 16'd0,     0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000, 10, 16'd0,     1, 1, 0, 1));
        // negative half-way tie rounds away from zero
        dir_rows.push_back(row(FUNC_LOAD, 3, 16'hffff,  0, 16'd0,     0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000,  7, 16'd1,     0, 0, 0, 0));
        dir_rows.push_back(row(FUNC_HIT,  0, 16'h0000,  4, 16'd1,     1, 0, 0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_item(dir_rows[k]);

        while (n_items < RAND_ITEMS) begin
            if (n_items >= 240) begin
                src_idle = 0;
                snk_idle = 0;
            end else if (n_items >= 120) begin
                src_idle = 57;
                snk_idle = 38;
                hold_req = 1'b1;
            end
            // Drive one cluster past both accumulator limits
            if (n_items >= 240 && !long_done) begin
                long_done = 1'b1;
                send_item(row(FUNC_LOAD, 20, 16'h8000, 0, 16'd0, 0, 0, 0, 0));
                for (i = 0; i < LONG_HITS; i++)
                    send_item(row(FUNC_HIT, 0, 16'h0000, 35, 16'hffff,
                                  (i == LONG_HITS - 1), 0, 0, 0));
            end
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 4)) send_load();
            end else begin
                len    = $urandom_range(1, 8);
                zero_e = ($urandom_range(0, 99) < 8);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(0, 99) < 10)
                        send_load();
                    send_hit(i == len - 1, zero_e);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (score_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
